// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, register indices and types for the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COLUMNS     = 1024;
  localparam int ROWS        = 1024;
  localparam int FRAC_BITS   = 28;
  localparam int RADIUS_FRAC = 24;
  localparam int MAG_SHIFT   = 2 * FRAC_BITS - RADIUS_FRAC;

  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 8;
  // pixel offset from the view centre, signed
  localparam int DC_W       = 14;
  // step * offset + centre before the range check
  localparam int C_W        = 47;
  // next z before the range check
  localparam int NZ_W       = 66 - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_RADIUS_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS   = 3'd4;

  localparam logic [30:0]        PIXEL_STEP_RST = 31'd1048576;
  localparam logic [31:0]        RADIUS_SQ_RST  = 32'd67108864;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST   = 8'd255;

  typedef struct packed {
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic [30:0]        pixel_step;
    logic [31:0]        escape_radius_sq;
    logic [COUNT_W-1:0] max_iterations;
  } cfg_t;

  // one classified pixel, handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic               trivial;
  } job_t;

endpackage

// ===== design/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel of a Mandelbrot view in signed Q4.28.
// ----------------------------------------------------------------------------
// A pixel (col, row) is mapped to c in the front stage and queued (two
// entries); the back end then runs z = z*z + c, each iteration passing
// through the shared bank of three 32x32 multipliers and then through the
// evaluate stage (magnitude compare, next z, range check). A pixel runs at
// most max_iterations + 1 iterations; the back end takes it from the queue
// in its idle state and loads the result register in its output state.
// Out-of-range points and a zero cap skip the loop. The result register
// lets the next pixel start while a result waits to be transferred.
// Configuration is to be written by the user only while idle; the block
// itself does not enforce it.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_W-1:0]    col,
  input  logic [COORD_W-1:0]    row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_W-1:0]    out_col,
  output logic [COORD_W-1:0]    out_row,
  output logic [COUNT_W-1:0]    iter_count
);

  cfg_t cfg;
  job_t front_job;
  job_t back_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_re        <= '0;
      cfg.center_im        <= '0;
      cfg.pixel_step       <= PIXEL_STEP_RST;
      cfg.escape_radius_sq <= RADIUS_SQ_RST;
      cfg.max_iterations   <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_RE:        cfg.center_re        <= cfg_data;
        REG_CENTER_IM:        cfg.center_im        <= cfg_data;
        REG_PIXEL_STEP:       cfg.pixel_step       <= cfg_data[30:0];
        REG_ESCAPE_RADIUS_SQ: cfg.escape_radius_sq <= cfg_data;
        REG_MAX_ITERATIONS:   cfg.max_iterations   <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  mbe_front u_front (
    .cfg (cfg),
    .col (col),
    .row (row),
    .job (front_job)
  );

  mbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .pop_job  (back_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job        (back_job),
    .job_valid  (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_col    (out_col),
    .out_row    (out_row),
    .iter_count (iter_count)
  );

endmodule

// ===== design/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// Maps a pixel to its point c and flags pixels whose count is zero outright.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; (
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output job_t               job
);

  logic signed [DC_W-1:0] dc;
  logic signed [DC_W-1:0] dr;
  logic signed [C_W-2:0]  pr_re;
  logic signed [C_W-2:0]  pr_im;
  logic signed [C_W-1:0]  cr_w;
  logic signed [C_W-1:0]  ci_w;
  logic                   cr_ok;
  logic                   ci_ok;

  always_comb begin
    dc    = $signed(DC_W'(col)) - $signed(DC_W'(COLUMNS / 2));
    dr    = $signed(DC_W'(ROWS / 2)) - $signed(DC_W'(row));
    pr_re = $signed({1'b0, cfg.pixel_step}) * dc;
    pr_im = $signed({1'b0, cfg.pixel_step}) * dr;
    cr_w  = $signed({pr_re[C_W-2], pr_re})
          + $signed({{(C_W-32){cfg.center_re[31]}}, cfg.center_re});
    ci_w  = $signed({pr_im[C_W-2], pr_im})
          + $signed({{(C_W-32){cfg.center_im[31]}}, cfg.center_im});
    cr_ok = (&cr_w[C_W-1:31]) || !(|cr_w[C_W-1:31]);
    ci_ok = (&ci_w[C_W-1:31]) || !(|ci_w[C_W-1:31]);

    job.col     = col;
    job.row     = row;
    job.cr      = cr_w[31:0];
    job.ci      = ci_w[31:0];
    job.trivial = !cr_ok || !ci_ok || (cfg.max_iterations == '0);
  end

endmodule

// ===== design/mbe_queue.sv =====
// ----------------------------------------------------------------------------
// mbe_queue
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module mbe_queue import mbe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== design/mbe_back.sv =====
// ----------------------------------------------------------------------------
// mbe_back
// Runs z = z*z + c for one pixel at a time and holds the result for transfer.
// ----------------------------------------------------------------------------
module mbe_back import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  job_t               job,
  input  logic               job_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic [COUNT_W-1:0] iter_count
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_EVAL = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t             state;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [63:0] xx;
  logic signed [63:0] yy;
  logic signed [63:0] xy;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] res_count;
  logic               pending;
  logic [COORD_W-1:0] cur_col;
  logic [COORD_W-1:0] cur_row;

  logic [63:0]           mag;
  logic [63:0]           mag_sh;
  logic [31:0]           m24;
  logic                  esc_mag;
  logic [COUNT_W-1:0]    n_inc;
  logic                  cap_hit;
  logic signed [NZ_W-1:0] nx;
  logic signed [NZ_W-1:0] ny;
  logic                  ovf;
  logic                  out_free;

  always_comb begin
    // products of the current z give both its magnitude and the next z
    mag     = $unsigned(xx) + $unsigned(yy);
    mag_sh  = mag >> MAG_SHIFT;
    m24     = (|mag_sh[63:32]) ? '1 : mag_sh[31:0];
    esc_mag = (m24 > cfg.escape_radius_sq);
    n_inc   = n + COUNT_W'(1);
    cap_hit = (n_inc == cfg.max_iterations);
    nx      = NZ_W'(xx >>> FRAC_BITS) - NZ_W'(yy >>> FRAC_BITS) + NZ_W'(cr);
    ny      = NZ_W'(xy >>> (FRAC_BITS - 1)) + NZ_W'(ci);
    ovf     = !((&nx[NZ_W-1:31]) || !(|nx[NZ_W-1:31]))
           || !((&ny[NZ_W-1:31]) || !(|ny[NZ_W-1:31]));
  end

  assign pop      = (state == S_IDLE) && job_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          x         <= job.cr;
          y         <= job.ci;
          cr        <= job.cr;
          ci        <= job.ci;
          cur_col   <= job.col;
          cur_row   <= job.row;
          n         <= '0;
          pending   <= 1'b0;
          res_count <= '0;
        end
      end
      S_MUL: begin
        xx <= x * x;
        yy <= y * y;
        xy <= x * y;
      end
      S_EVAL: begin
        priority if (pending && esc_mag) begin
          res_count <= n;
        end else if (pending && cap_hit) begin
          res_count <= n_inc;
        end else if (ovf) begin
          res_count <= pending ? n_inc : n;
        end else begin
          x       <= nx[31:0];
          y       <= ny[31:0];
          n       <= pending ? n_inc : n;
          pending <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_col    <= cur_col;
          out_row    <= cur_row;
          iter_count <= res_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= job.trivial ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if ((pending && (esc_mag || cap_hit)) || ovf) begin
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/mbe_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker import mbe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_col,
  input logic [COORD_W-1:0] out_row,
  input logic [COUNT_W-1:0] iter_count
);

  // pixels taken in and not yet transferred out
  logic [2:0] outstanding;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row)
                               && $stable(iter_count))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> outstanding != 3'd0)
    else $error("result transferred with no pixel outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd4)
    else $error("more pixels outstanding than queue, back end and output hold");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_col    (out_col),
  .out_row    (out_row),
  .iter_count (iter_count)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mandelbrot_escape_time. Pixels go in through a
// valid/stall channel and each count is checked against a bit-exact escape
// count worked out here. It starts with a short table of directed pixels and
// register writes, then runs views with random centres, steps, radii and caps,
// random idling on both channels and one long hold on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int PHASES          = 10;
  localparam int PIXELS_PER_VIEW = 100;
  localparam int PRESSURE_PHASE  = 1;
  localparam int HOLD_CYCLES     = 3000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int MAX_REPORTS     = 50;

  localparam longint I32_LO = -64'sd2147483648;
  localparam longint I32_HI = 64'sd2147483647;

  // indices with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_t;

  typedef struct {
    plan_kind_t            kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [COORD_W-1:0]    px_col;
    logic [COORD_W-1:0]    px_row;
    bit                    typed;
    logic [COUNT_W-1:0]    count;
  } plan_row_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COUNT_W-1:0] count;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    col;
  logic [COORD_W-1:0]    row;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_W-1:0]    out_col;
  logic [COORD_W-1:0]    out_row;
  logic [COUNT_W-1:0]    iter_count;

  cfg_t          view;
  pixel_result_t expected_pixels[$];
  pixel_result_t oldest;
  plan_row_t     plan[$];
  int            mismatches = 0;

  // result-side idling, owned by the receiver process
  bit rx_gaps     = 1'b1;
  bit quiet       = 1'b0;
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int burst_left  = 0;
  bit tx_gaps;

  mandelbrot_escape_time DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .col        (col),
    .row        (row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_col    (out_col),
    .out_row    (out_row),
    .iter_count (iter_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  // Escape count for one pixel under the current view.
  function automatic logic [COUNT_W-1:0] escape_count(input logic [COORD_W-1:0] px_col,
                                                      input logic [COORD_W-1:0] px_row);
    longint            pt_re, pt_im, x, y, nx, ny;
    longint unsigned   mag, m24;
    int                n;
    pt_re = longint'(view.pixel_step) * (longint'(px_col) - COLUMNS / 2)
            + longint'($signed(view.center_re));
    pt_im = longint'(view.pixel_step) * (ROWS / 2 - longint'(px_row))
            + longint'($signed(view.center_im));
    if (pt_re < I32_LO || pt_re > I32_HI || pt_im < I32_LO || pt_im > I32_HI)
      return '0;
    x = pt_re;
    y = pt_im;
    n = 0;
    while (n < int'(view.max_iterations)) begin
      // arithmetic shifts give floor division
      nx = ((x * x) >>> FRAC_BITS) - ((y * y) >>> FRAC_BITS) + pt_re;
      ny = ((x * y) >>> (FRAC_BITS - 1)) + pt_im;
      if (nx < I32_LO || nx > I32_HI || ny < I32_LO || ny > I32_HI)
        break;
      x = nx;
      y = ny;
      mag = $unsigned(x * x) + $unsigned(y * y);
      m24 = mag >> MAG_SHIFT;
      if (m24 > 64'h0000_0000_FFFF_FFFF)
        m24 = 64'h0000_0000_FFFF_FFFF;
      if (m24 > {32'b0, view.escape_radius_sq})
        break;
      n++;
    end
    return n[COUNT_W-1:0];
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t entry;
    entry.kind   = PLAN_WRITE;
    entry.index  = index;
    entry.data   = data;
    entry.px_col = '0;
    entry.px_row = '0;
    entry.typed  = 1'b0;
    entry.count  = '0;
    return entry;
  endfunction

  function automatic plan_row_t pixel_row(input logic [COORD_W-1:0] px_col,
                                          input logic [COORD_W-1:0] px_row,
                                          input bit typed, input logic [COUNT_W-1:0] count);
    plan_row_t entry;
    entry.kind   = PLAN_PIXEL;
    entry.index  = '0;
    entry.data   = '0;
    entry.px_col = px_col;
    entry.px_row = px_row;
    entry.typed  = typed;
    entry.count  = count;
    return entry;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      REG_CENTER_RE:        view.center_re        = data;
      REG_CENTER_IM:        view.center_im        = data;
      REG_PIXEL_STEP:       view.pixel_step       = data[30:0];
      REG_ESCAPE_RADIUS_SQ: view.escape_radius_sq = data;
      REG_MAX_ITERATIONS:   view.max_iterations   = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel and hold it until the transfer; record what should come back.
  task automatic send_pixel(input logic [COORD_W-1:0] px_col, input logic [COORD_W-1:0] px_row,
                            input bit typed, input logic [COUNT_W-1:0] typed_count);
    pixel_result_t want;
    cfg_we   <= 1'b0;
    in_valid <= 1'b1;
    col      <= px_col;
    row      <= px_row;
    do @(posedge clk); while (in_stall);
    want.col   = px_col;
    want.row   = px_row;
    want.count = typed ? typed_count : escape_count(px_col, px_row);
    expected_pixels.push_back(want);
  endtask

  task automatic hold_back_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Block is idle once every pixel sent has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic pick_view();
    logic [31:0]        re_pick, im_pick, radius_pick;
    logic [30:0]        step_pick;
    logic [COUNT_W-1:0] cap_pick;
    if ($urandom_range(0, 7) == 0) begin
      re_pick     = $urandom;
      im_pick     = $urandom;
      step_pick   = 31'($urandom);
      radius_pick = $urandom;
    end else begin
      // centre in [-2, 1] x [-1, 1], span from 1024 ulps up to 4.0
      re_pick   = $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
      im_pick   = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      step_pick = 31'($urandom_range(1, 1 << $urandom_range(4, 20)));
      case ($urandom_range(0, 5))
        0:       radius_pick = $urandom;
        1:       radius_pick = '1;
        default: radius_pick = RADIUS_SQ_RST;
      endcase
    end
    case ($urandom_range(0, 11))
      0:       cap_pick = '0;
      1, 2:    cap_pick = MAX_ITER_RST;
      default: cap_pick = COUNT_W'($urandom_range(1, 48));
    endcase
    write_reg(REG_CENTER_RE, re_pick);
    write_reg(REG_CENTER_IM, im_pick);
    // unused upper bits carry noise
    write_reg(REG_PIXEL_STEP, {1'($urandom_range(0, 1)), step_pick});
    write_reg(REG_ESCAPE_RADIUS_SQ, radius_pick);
    write_reg(REG_MAX_ITERATIONS, {24'($urandom), cap_pick});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  = 0;
      burst_left = 0;
    end else begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet && rx_gaps && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result col %0d row %0d count %0d",
                                  out_col, out_row, iter_count));
      end else begin
        oldest = expected_pixels.pop_front();
        if (out_col !== oldest.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", out_col, oldest.col));
        if (out_row !== oldest.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_row, oldest.row));
        if (iter_count !== oldest.count)
          report_mismatch($sformatf("iter_count %0d, expected %0d (col %0d row %0d)",
                                    iter_count, oldest.count, oldest.col, oldest.row));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    col       = '0;
    row       = '0;
    tx_gaps   = 1'b0;
    view.center_re        = '0;
    view.center_im        = '0;
    view.pixel_step       = PIXEL_STEP_RST;
    view.escape_radius_sq = RADIUS_SQ_RST;
    view.max_iterations   = MAX_ITER_RST;

    // writes to unused indices must change nothing
    plan.push_back(reg_row(REG_SPARE_LO, '1));
    plan.push_back(reg_row(REG_SPARE_HI, '1));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b1, 8'd255));
    plan.push_back(pixel_row(10'd0, 10'd0, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd1023, 10'd1023, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd0, 10'd1023, 1'b0, '0));
    plan.push_back(pixel_row(10'd1023, 10'd0, 1'b0, '0));
    plan.push_back(pixel_row(10'd384, 10'd512, 1'b0, '0));
    // c = -2 sits on |z|^2 == radius for ever
    plan.push_back(pixel_row(10'd0, 10'd512, 1'b0, '0));
    plan.push_back(reg_row(REG_MAX_ITERATIONS, 32'd0));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd1023, 10'd1023, 1'b1, 8'd0));
    plan.push_back(reg_row(REG_MAX_ITERATIONS, 32'd1));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b1, 8'd1));
    plan.push_back(reg_row(REG_MAX_ITERATIONS, 32'd255));
    plan.push_back(reg_row(REG_ESCAPE_RADIUS_SQ, 32'hFFFF_FFFF));
    plan.push_back(pixel_row(10'd0, 10'd0, 1'b0, '0));
    plan.push_back(pixel_row(10'd1023, 10'd1023, 1'b1, 8'd0));
    plan.push_back(reg_row(REG_ESCAPE_RADIUS_SQ, 32'd0));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b1, 8'd255));
    plan.push_back(pixel_row(10'd513, 10'd512, 1'b0, '0));
    plan.push_back(reg_row(REG_PIXEL_STEP, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_CENTER_RE, 32'h7FFF_FFFF));
    plan.push_back(pixel_row(10'd1023, 10'd512, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd0, 10'd512, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b0, '0));
    plan.push_back(reg_row(REG_CENTER_IM, 32'h8000_0000));
    plan.push_back(pixel_row(10'd512, 10'd0, 1'b1, 8'd0));
    plan.push_back(pixel_row(10'd512, 10'd512, 1'b0, '0));
    plan.push_back(reg_row(REG_CENTER_RE, 32'd0));
    plan.push_back(reg_row(REG_CENTER_IM, 32'd0));
    plan.push_back(reg_row(REG_PIXEL_STEP, 32'd1));
    plan.push_back(pixel_row(10'd0, 10'd0, 1'b0, '0));
    plan.push_back(pixel_row(10'd1023, 10'd1023, 1'b0, '0));
    // every pixel collapses onto the centre
    plan.push_back(reg_row(REG_PIXEL_STEP, 32'd0));
    plan.push_back(pixel_row(10'd1023, 10'd0, 1'b1, 8'd255));
    plan.push_back(pixel_row(10'd0, 10'd1023, 1'b1, 8'd255));
    plan.push_back(reg_row(REG_PIXEL_STEP, {1'b0, PIXEL_STEP_RST}));
    plan.push_back(reg_row(REG_ESCAPE_RADIUS_SQ, RADIUS_SQ_RST));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_WRITE) begin
        drain();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_pixel(plan[i].px_col, plan[i].px_row, plan[i].typed, plan[i].count);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      pick_view();
      if (phase == PHASES - 1) begin
        quiet   = 1'b1;
        tx_gaps = 1'b0;
      end else begin
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_gaps = $urandom_range(0, 3) != 0;
      end
      // result side holds off while pixels keep coming
      if (phase == PRESSURE_PHASE)
        holds_asked++;
      for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
        send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                   1'b0, '0);
        if (tx_gaps && $urandom_range(0, 3) == 0)
          hold_back_sender($urandom_range(1, 14));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
